/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the segment crossing block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEGX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEGX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/segx_pkg.sv */
// Shared types and constants for the segment crossing pipeline.
// No dependencies; every module refers to it by scoped names.
`default_nettype none

package segx_pkg;

    // Default coordinate width of the endpoints and of the crossing point.
    localparam int COORD_WIDTH_DEF = 16;

    // Per-item control and status that travels down the pipeline.
    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
        logic rem_nz_x;
        logic rem_nz_y;
    } ctl_t;

endpackage

`default_nettype wire

/* rtl/segx_front.sv */
// Geometry front end: differences, cross products, sign normalization and hit test.
// Five register stages; depends on segx_pkg for the control struct.
`default_nettype none

module segx_front #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          item_valid,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic signed [COORD_WIDTH-1:0] cx,
    input  wire logic signed [COORD_WIDTH-1:0] cy,
    input  wire logic signed [COORD_WIDTH-1:0] dx,
    input  wire logic signed [COORD_WIDTH-1:0] dy,
    output segx_pkg::ctl_t                     ctl,
    output logic        [2*COORD_WIDTH:0]      den,
    output logic        [2*COORD_WIDTH:0]      mn,
    output logic        [COORD_WIDTH-1:0]      jx_mag,
    output logic        [COORD_WIDTH-1:0]      jy_mag,
    output logic signed [COORD_WIDTH-1:0]      cx_dly,
    output logic signed [COORD_WIDTH-1:0]      cy_dly
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int NW = 2 * W + 3;
    localparam int MW = 2 * W + 1;

    logic valid_reg [1:5];

    // Stage 1: coordinate differences.
    logic signed [DW-1:0] s1_ix_next, s1_iy_next, s1_jx_next, s1_jy_next;
    logic signed [DW-1:0] s1_acx_next, s1_acy_next;
    logic signed [DW-1:0] s1_ix_reg, s1_iy_reg, s1_jx_reg, s1_jy_reg;
    logic signed [DW-1:0] s1_acx_reg, s1_acy_reg;

    // Stage 2: the six cross-product terms.
    logic signed [PW-1:0] s2_ixjy_next, s2_iyjx_next, s2_ixacy_next;
    logic signed [PW-1:0] s2_iyacx_next, s2_acyjx_next, s2_acxjy_next;
    logic signed [PW-1:0] s2_ixjy_reg, s2_iyjx_reg, s2_ixacy_reg;
    logic signed [PW-1:0] s2_iyacx_reg, s2_acyjx_reg, s2_acxjy_reg;
    logic        [DW-1:0] jx_abs, jy_abs;

    // Stage 3: denominator and the two numerators.
    logic signed [NW-1:0] s3_den_next, s3_mn_next, s3_kn_next;
    logic signed [NW-1:0] s3_den_reg, s3_mn_reg, s3_kn_reg;

    // Stage 4: the denominator made nonnegative, with the numerators negated alongside.
    logic signed [NW-1:0] s4_den_next, s4_mn_next, s4_kn_next;
    logic signed [NW-1:0] s4_den_reg, s4_mn_reg, s4_kn_reg;
    logic                 s4_zero_next, s4_zero_reg;

    // Stage 5: strict interior test on both parameters.
    logic                 s5_hit_next, s5_hit_reg;
    logic        [MW-1:0] s5_den_reg, s5_mn_reg;

    // Side data carried alongside the arithmetic.
    logic        [W-1:0]  jxm_reg [2:5];
    logic        [W-1:0]  jym_reg [2:5];
    logic                 negx_reg [2:5];
    logic                 negy_reg [2:5];
    logic signed [W-1:0]  cx_reg [1:5];
    logic signed [W-1:0]  cy_reg [1:5];

    always_comb
    begin
        s1_ix_next  = $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
        s1_iy_next  = $signed({by[W-1], by}) - $signed({ay[W-1], ay});
        s1_jx_next  = $signed({dx[W-1], dx}) - $signed({cx[W-1], cx});
        s1_jy_next  = $signed({dy[W-1], dy}) - $signed({cy[W-1], cy});
        s1_acx_next = $signed({ax[W-1], ax}) - $signed({cx[W-1], cx});
        s1_acy_next = $signed({ay[W-1], ay}) - $signed({cy[W-1], cy});

        s2_ixjy_next  = PW'(s1_ix_reg)  * PW'(s1_jy_reg);
        s2_iyjx_next  = PW'(s1_iy_reg)  * PW'(s1_jx_reg);
        s2_ixacy_next = PW'(s1_ix_reg)  * PW'(s1_acy_reg);
        s2_iyacx_next = PW'(s1_iy_reg)  * PW'(s1_acx_reg);
        s2_acyjx_next = PW'(s1_acy_reg) * PW'(s1_jx_reg);
        s2_acxjy_next = PW'(s1_acx_reg) * PW'(s1_jy_reg);
        jx_abs = s1_jx_reg[DW-1] ? DW'(-s1_jx_reg) : DW'(s1_jx_reg);
        jy_abs = s1_jy_reg[DW-1] ? DW'(-s1_jy_reg) : DW'(s1_jy_reg);

        s3_den_next = NW'(s2_ixjy_reg)  - NW'(s2_iyjx_reg);
        s3_mn_next  = NW'(s2_ixacy_reg) - NW'(s2_iyacx_reg);
        s3_kn_next  = NW'(s2_acyjx_reg) - NW'(s2_acxjy_reg);

        s4_zero_next = (s3_den_reg == '0);
        if (s3_den_reg[NW-1])
        begin
            s4_den_next = -s3_den_reg;
            s4_mn_next  = -s3_mn_reg;
            s4_kn_next  = -s3_kn_reg;
        end
        else
        begin
            s4_den_next = s3_den_reg;
            s4_mn_next  = s3_mn_reg;
            s4_kn_next  = s3_kn_reg;
        end

        s5_hit_next = !s4_zero_reg
                      && (s4_mn_reg > 0) && (s4_mn_reg < s4_den_reg)
                      && (s4_kn_reg > 0) && (s4_kn_reg < s4_den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 5; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[1] <= item_valid;
            for (int k = 2; k <= 5; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ix_reg  <= s1_ix_next;
            s1_iy_reg  <= s1_iy_next;
            s1_jx_reg  <= s1_jx_next;
            s1_jy_reg  <= s1_jy_next;
            s1_acx_reg <= s1_acx_next;
            s1_acy_reg <= s1_acy_next;

            s2_ixjy_reg  <= s2_ixjy_next;
            s2_iyjx_reg  <= s2_iyjx_next;
            s2_ixacy_reg <= s2_ixacy_next;
            s2_iyacx_reg <= s2_iyacx_next;
            s2_acyjx_reg <= s2_acyjx_next;
            s2_acxjy_reg <= s2_acxjy_next;

            s3_den_reg <= s3_den_next;
            s3_mn_reg  <= s3_mn_next;
            s3_kn_reg  <= s3_kn_next;

            s4_den_reg  <= s4_den_next;
            s4_mn_reg   <= s4_mn_next;
            s4_kn_reg   <= s4_kn_next;
            s4_zero_reg <= s4_zero_next;

            // After normalization both values are nonnegative and fit MW bits on a hit.
            s5_hit_reg <= s5_hit_next;
            s5_den_reg <= s4_den_reg[MW-1:0];
            s5_mn_reg  <= s4_mn_reg[MW-1:0];

            jxm_reg[2]  <= jx_abs[W-1:0];
            jym_reg[2]  <= jy_abs[W-1:0];
            negx_reg[2] <= s1_jx_reg[DW-1];
            negy_reg[2] <= s1_jy_reg[DW-1];
            for (int k = 3; k <= 5; k++)
            begin
                jxm_reg[k]  <= jxm_reg[k-1];
                jym_reg[k]  <= jym_reg[k-1];
                negx_reg[k] <= negx_reg[k-1];
                negy_reg[k] <= negy_reg[k-1];
            end

            cx_reg[1] <= cx;
            cy_reg[1] <= cy;
            for (int k = 2; k <= 5; k++)
            begin
                cx_reg[k] <= cx_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
            end
        end
    end

    always_comb
    begin
        ctl.valid    = valid_reg[5];
        ctl.hit      = s5_hit_reg;
        ctl.neg_x    = negx_reg[5];
        ctl.neg_y    = negy_reg[5];
        ctl.rem_nz_x = 1'b0;
        ctl.rem_nz_y = 1'b0;
    end

    assign den    = s5_den_reg;
    assign mn     = s5_mn_reg;
    assign jx_mag = jxm_reg[5];
    assign jy_mag = jym_reg[5];
    assign cx_dly = cx_reg[5];
    assign cy_dly = cy_reg[5];

endmodule

`default_nettype wire

/* rtl/segx_scale.sv */
// Scaled offset magnitudes |mn * J| for x and y, built from split partial products.
// Two register stages; depends on segx_pkg for the control struct.
`default_nettype none

module segx_scale #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire segx_pkg::ctl_t                f_ctl,
    input  wire logic        [2*COORD_WIDTH:0] f_den,
    input  wire logic        [2*COORD_WIDTH:0] f_mn,
    input  wire logic        [COORD_WIDTH-1:0] f_jx_mag,
    input  wire logic        [COORD_WIDTH-1:0] f_jy_mag,
    input  wire logic signed [COORD_WIDTH-1:0] f_cx,
    input  wire logic signed [COORD_WIDTH-1:0] f_cy,
    output segx_pkg::ctl_t                     ctl,
    output logic        [2*COORD_WIDTH:0]      den,
    output logic        [3*COORD_WIDTH:0]      tx_mag,
    output logic        [3*COORD_WIDTH:0]      ty_mag,
    output logic signed [COORD_WIDTH-1:0]      cx_dly,
    output logic signed [COORD_WIDTH-1:0]      cy_dly
);

    localparam int W   = COORD_WIDTH;
    localparam int MW  = 2 * W + 1;
    localparam int LPW = 2 * W;
    localparam int HPW = 2 * W + 1;
    localparam int TW  = 3 * W + 1;

    segx_pkg::ctl_t      ctl6_reg, ctl7_reg;
    logic [LPW-1:0]      ppxl_next, ppyl_next, ppxl_reg, ppyl_reg;
    logic [HPW-1:0]      ppxh_next, ppyh_next, ppxh_reg, ppyh_reg;
    logic [TW-1:0]       tx_next, ty_next, tx_reg, ty_reg;
    logic [MW-1:0]       den6_reg, den7_reg;
    logic signed [W-1:0] cx6_reg, cy6_reg, cx7_reg, cy7_reg;

    always_comb
    begin
        ppxl_next = LPW'(f_mn[W-1:0])  * LPW'(f_jx_mag);
        ppyl_next = LPW'(f_mn[W-1:0])  * LPW'(f_jy_mag);
        ppxh_next = HPW'(f_mn[MW-1:W]) * HPW'(f_jx_mag);
        ppyh_next = HPW'(f_mn[MW-1:W]) * HPW'(f_jy_mag);
        tx_next   = TW'(ppxl_reg) + (TW'(ppxh_reg) << W);
        ty_next   = TW'(ppyl_reg) + (TW'(ppyh_reg) << W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end
        else if (advance)
        begin
            ctl6_reg <= f_ctl;
            ctl7_reg <= ctl6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ppxl_reg <= ppxl_next;
            ppyl_reg <= ppyl_next;
            ppxh_reg <= ppxh_next;
            ppyh_reg <= ppyh_next;
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            den6_reg <= f_den;
            den7_reg <= den6_reg;
            cx6_reg  <= f_cx;
            cy6_reg  <= f_cy;
            cx7_reg  <= cx6_reg;
            cy7_reg  <= cy6_reg;
        end
    end

    assign ctl    = ctl7_reg;
    assign den    = den7_reg;
    assign tx_mag = tx_reg;
    assign ty_mag = ty_reg;
    assign cx_dly = cx7_reg;
    assign cy_dly = cy7_reg;

endmodule

`default_nettype wire

/* rtl/segx_div.sv */
// Pipelined restoring divider: one quotient bit per stage for x and y in parallel.
// COORD_WIDTH register stages; depends on segx_pkg for the control struct.
`default_nettype none

module segx_div #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire segx_pkg::ctl_t                s_ctl,
    input  wire logic        [2*COORD_WIDTH:0] s_den,
    input  wire logic        [3*COORD_WIDTH:0] s_tx_mag,
    input  wire logic        [3*COORD_WIDTH:0] s_ty_mag,
    input  wire logic signed [COORD_WIDTH-1:0] s_cx,
    input  wire logic signed [COORD_WIDTH-1:0] s_cy,
    output segx_pkg::ctl_t                     ctl,
    output logic        [COORD_WIDTH-1:0]      qx,
    output logic        [COORD_WIDTH-1:0]      qy,
    output logic signed [COORD_WIDTH-1:0]      cx_dly,
    output logic signed [COORD_WIDTH-1:0]      cy_dly
);

    localparam int W  = COORD_WIDTH;
    localparam int MW = 2 * W + 1;
    localparam int TW = 3 * W + 1;

    segx_pkg::ctl_t      ctl_next  [W];
    segx_pkg::ctl_t      ctl_reg   [W];
    logic [MW-1:0]       den_next  [W];
    logic [MW-1:0]       den_reg   [W];
    logic [TW-1:0]       remx_next [W];
    logic [TW-1:0]       remx_reg  [W];
    logic [TW-1:0]       remy_next [W];
    logic [TW-1:0]       remy_reg  [W];
    logic [W-1:0]        qx_next   [W];
    logic [W-1:0]        qx_reg    [W];
    logic [W-1:0]        qy_next   [W];
    logic [W-1:0]        qy_reg    [W];
    logic signed [W-1:0] cx_next   [W];
    logic signed [W-1:0] cx_reg    [W];
    logic signed [W-1:0] cy_next   [W];
    logic signed [W-1:0] cy_reg    [W];

    // Stage k decides quotient bit W-1-k. Since |t| < den * 2^W, the partial
    // remainder entering stage k is always below den shifted by W-k.
    always_comb
    begin
        for (int k = 0; k < W; k++)
        begin
            logic [TW-1:0] rx, ry, dsh;
            logic [W-1:0]  qxs, qys;
            logic          gex, gey;
            if (k == 0)
            begin
                ctl_next[k] = s_ctl;
                den_next[k] = s_den;
                cx_next[k]  = s_cx;
                cy_next[k]  = s_cy;
                rx          = s_tx_mag;
                ry          = s_ty_mag;
                qxs         = '0;
                qys         = '0;
            end
            else
            begin
                ctl_next[k] = ctl_reg[k-1];
                den_next[k] = den_reg[k-1];
                cx_next[k]  = cx_reg[k-1];
                cy_next[k]  = cy_reg[k-1];
                rx          = remx_reg[k-1];
                ry          = remy_reg[k-1];
                qxs         = qx_reg[k-1];
                qys         = qy_reg[k-1];
            end
            dsh          = TW'(den_next[k]) << (W - 1 - k);
            gex          = (rx >= dsh);
            gey          = (ry >= dsh);
            remx_next[k] = gex ? (rx - dsh) : rx;
            remy_next[k] = gey ? (ry - dsh) : ry;
            qx_next[k]   = {qxs[W-2:0], gex};
            qy_next[k]   = {qys[W-2:0], gey};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < W; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            for (int k = 0; k < W; k++)
            begin
                ctl_reg[k] <= ctl_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < W; k++)
            begin
                den_reg[k]  <= den_next[k];
                remx_reg[k] <= remx_next[k];
                remy_reg[k] <= remy_next[k];
                qx_reg[k]   <= qx_next[k];
                qy_reg[k]   <= qy_next[k];
                cx_reg[k]   <= cx_next[k];
                cy_reg[k]   <= cy_next[k];
            end
        end
    end

    always_comb
    begin
        ctl          = ctl_reg[W-1];
        ctl.rem_nz_x = (remx_reg[W-1] != '0);
        ctl.rem_nz_y = (remy_reg[W-1] != '0);
    end

    assign qx     = qx_reg[W-1];
    assign qy     = qy_reg[W-1];
    assign cx_dly = cx_reg[W-1];
    assign cy_dly = cy_reg[W-1];

endmodule

`default_nettype wire

/* rtl/segx_out.sv */
// Final rounding of the crossing point and the output register with its skid stage.
// Depends on segx_pkg for the control struct.
`default_nettype none

module segx_out #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire segx_pkg::ctl_t                d_ctl,
    input  wire logic        [COORD_WIDTH-1:0] d_qx,
    input  wire logic        [COORD_WIDTH-1:0] d_qy,
    input  wire logic signed [COORD_WIDTH-1:0] d_cx,
    input  wire logic signed [COORD_WIDTH-1:0] d_cy,
    input  wire logic                          result_stall,
    output logic                               advance,
    output logic                               result_valid,
    output logic                               hit,
    output logic signed [COORD_WIDTH-1:0]      px,
    output logic signed [COORD_WIDTH-1:0]      py
);

    localparam int W = COORD_WIDTH;

    // C + t/den truncated toward zero, from the unsigned quotient of |t|/den.
    // The floor quotient is -q-1 when t is negative with a remainder; a negative
    // sum with a remainder then moves up by one.
    function automatic logic signed [W-1:0] round_point(
        input logic signed [W-1:0] c,
        input logic        [W-1:0] q,
        input logic                neg,
        input logic                rnz
    );
        logic signed [W+1:0] qf;
        logic signed [W+1:0] s;
        if (neg)
        begin
            qf = rnz ? $signed(~{2'b00, q}) : -$signed({2'b00, q});
        end
        else
        begin
            qf = $signed({2'b00, q});
        end
        s = $signed({{2{c[W-1]}}, c}) + qf;
        if (s[W+1] && rnz)
        begin
            s = s + (W+2)'(1);
        end
        return s[W-1:0];
    endfunction

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                out_load, skid_load, from_skid;
    logic                fix_hit;
    logic signed [W-1:0] fix_px, fix_py;
    logic                out_hit_reg, skid_hit_reg;
    logic signed [W-1:0] out_px_reg, out_py_reg, skid_px_reg, skid_py_reg;

    always_comb
    begin
        fix_hit = d_ctl.hit;
        fix_px  = d_ctl.hit ? round_point(d_cx, d_qx, d_ctl.neg_x, d_ctl.rem_nz_x) : '0;
        fix_py  = d_ctl.hit ? round_point(d_cy, d_qy, d_ctl.neg_y, d_ctl.rem_nz_y) : '0;

        advance         = !skid_valid_reg;
        out_load        = 1'b0;
        skid_load       = 1'b0;
        from_skid       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!skid_valid_reg)
        begin
            if (!out_valid_reg || !result_stall)
            begin
                out_load       = 1'b1;
                out_valid_next = d_ctl.valid;
            end
            else if (d_ctl.valid)
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (!result_stall)
        begin
            from_skid       = 1'b1;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_hit_reg <= fix_hit;
            out_px_reg  <= fix_px;
            out_py_reg  <= fix_py;
        end
        else if (from_skid)
        begin
            out_hit_reg <= skid_hit_reg;
            out_px_reg  <= skid_px_reg;
            out_py_reg  <= skid_py_reg;
        end
        if (skid_load)
        begin
            skid_hit_reg <= fix_hit;
            skid_px_reg  <= fix_px;
            skid_py_reg  <= fix_py;
        end
    end

    assign result_valid = out_valid_reg;
    assign hit          = out_hit_reg;
    assign px           = out_px_reg;
    assign py           = out_py_reg;

endmodule

`default_nettype wire

/* rtl/segment_intersection.sv */
// Top level of the 2-D segment crossing pipeline; uses segx_pkg and the segx_* stages.
// Throughput: one transaction per cycle while item_stall is low. Seven stages of
// geometry and products come first, then the divider with one quotient bit per
// stage for COORD_WIDTH stages.
// Reset: rst_n is asynchronous and active low and clears every valid bit.
`default_nettype none

module segment_intersection #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic signed [COORD_WIDTH-1:0] cx,
    input  wire logic signed [COORD_WIDTH-1:0] cy,
    input  wire logic signed [COORD_WIDTH-1:0] dx,
    input  wire logic signed [COORD_WIDTH-1:0] dy,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               hit,
    output logic signed [COORD_WIDTH-1:0]      px,
    output logic signed [COORD_WIDTH-1:0]      py
);

    // With I = B - A and J = D - C, the block forms den = I x J and the numerators
    // of the parameters along CD (mn) and AB (kn). After the sign of den is folded
    // into all three, a hit needs 0 < mn < den and 0 < kn < den, so an endpoint
    // touch, parallel lines and a degenerate segment all give no hit and (0,0).
    //
    // On a hit the crossing is C + mn*J/den. The front end passes |J| and the sign
    // of J, the scale stages form |mn*J|, and the divider yields the quotient and
    // whether the remainder is nonzero. The output stage rebuilds the exact value
    // truncated toward zero from those pieces.
    //
    // All stages move together on one advance signal. A skid register behind the
    // output register holds one more result, so a transaction is still accepted
    // while a finished result waits; item_stall rises only once the skid is full,
    // and it comes straight from a register.

    localparam int W  = COORD_WIDTH;
    localparam int MW = 2 * W + 1;
    localparam int TW = 3 * W + 1;

    logic                advance;

    segx_pkg::ctl_t      f_ctl;
    logic [MW-1:0]       f_den, f_mn;
    logic [W-1:0]        f_jx_mag, f_jy_mag;
    logic signed [W-1:0] f_cx, f_cy;

    segx_pkg::ctl_t      s_ctl;
    logic [MW-1:0]       s_den;
    logic [TW-1:0]       s_tx_mag, s_ty_mag;
    logic signed [W-1:0] s_cx, s_cy;

    segx_pkg::ctl_t      d_ctl;
    logic [W-1:0]        d_qx, d_qy;
    logic signed [W-1:0] d_cx, d_cy;

    segx_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (item_valid),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by         (by),
        .cx         (cx),
        .cy         (cy),
        .dx         (dx),
        .dy         (dy),
        .ctl        (f_ctl),
        .den        (f_den),
        .mn         (f_mn),
        .jx_mag     (f_jx_mag),
        .jy_mag     (f_jy_mag),
        .cx_dly     (f_cx),
        .cy_dly     (f_cy)
    );

    segx_scale #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .f_ctl    (f_ctl),
        .f_den    (f_den),
        .f_mn     (f_mn),
        .f_jx_mag (f_jx_mag),
        .f_jy_mag (f_jy_mag),
        .f_cx     (f_cx),
        .f_cy     (f_cy),
        .ctl      (s_ctl),
        .den      (s_den),
        .tx_mag   (s_tx_mag),
        .ty_mag   (s_ty_mag),
        .cx_dly   (s_cx),
        .cy_dly   (s_cy)
    );

    segx_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .s_ctl    (s_ctl),
        .s_den    (s_den),
        .s_tx_mag (s_tx_mag),
        .s_ty_mag (s_ty_mag),
        .s_cx     (s_cx),
        .s_cy     (s_cy),
        .ctl      (d_ctl),
        .qx       (d_qx),
        .qy       (d_qy),
        .cx_dly   (d_cx),
        .cy_dly   (d_cy)
    );

    segx_out #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .d_ctl        (d_ctl),
        .d_qx         (d_qx),
        .d_qy         (d_qy),
        .d_cx         (d_cx),
        .d_cy         (d_cy),
        .result_stall (result_stall),
        .advance      (advance),
        .result_valid (result_valid),
        .hit          (hit),
        .px           (px),
        .py           (py)
    );

    // The pipeline holds exactly when the skid register is occupied.
    assign item_stall = !advance;

endmodule

`default_nettype wire

/* rtl/segx_checker.sv */
// Port-level checker for segment_intersection, attached by the bind at the end.
// Depends on assert_macros.svh and segx_pkg.
`default_nettype none
`include "assert_macros.svh"

module segx_checker #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_stall,
    input wire logic                          result_valid,
    input wire logic                          result_stall,
    input wire logic                          hit,
    input wire logic signed [COORD_WIDTH-1:0] px,
    input wire logic signed [COORD_WIDTH-1:0] py
);

    // A stalled result transaction keeps its payload.
    `SEGX_ASSERT_NEXT(a_result_hold,
                      result_valid && result_stall,
                      result_valid && $stable(hit) && $stable(px) && $stable(py),
                      "stalled result changed")

    // A miss always reports the origin.
    `SEGX_ASSERT_NOW(a_miss_origin, result_valid && !hit, px == '0 && py == '0,
                     "miss with nonzero point")

    // The input only stalls while a result is waiting at the output.
    `SEGX_ASSERT_NOW(a_stall_needs_result, item_stall, result_valid,
                     "input stalled with empty output")

    // Once the output is taken, the skid drains and the input opens again.
    `SEGX_ASSERT_NEXT(a_skid_drains, item_stall && !result_stall, !item_stall,
                      "input stall did not clear")

endmodule

bind segment_intersection segx_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

`default_nettype wire
